### src/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Standalone header; expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/mtvm_pkg.sv
// Shared types and constants for the transposed matrix-vector multiply unit.
// No dependencies.
package mtvm_pkg;

    localparam int MAX_N_DEF = 64;

    localparam int MODE_W = 2;
    localparam int IDX_W  = 6;
    localparam int VAL_W  = 16;
    localparam int SUM_W  = 32;
    localparam int SIZE_W = 7;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index, taken from paddr above the byte lane bits
    localparam logic REG_SIZE_IN_USE = 1'b0;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_LOAD_VEC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_MAT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE  = 2'd2;

    // Flags that travel with one multiply-accumulate step down the pipe
    typedef struct packed {
        logic             valid;
        logic             first_row;
        logic             last_row;
        logic             last_col;
        logic [IDX_W-1:0] col;
    } t_tag;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

endpackage

### src/matrix_transpose_vector_multiply_unit.sv
// Top level of the transposed matrix-vector multiply unit: vector and matrix
// stores, one shared 16x16 multiplier and accumulator under a small sequencer.
// Depends on mtvm_pkg and assert_macros.svh.
//
//  channel   signals                                   direction  handshake
//  command   start, i_mode, i_row, i_col, i_value      in         start & !busy
//  result    o_valid, o_column, o_total, o_last        out        o_valid, no stall
//  config    psel, penable, pwrite, paddr, pwdata,     in/out     APB, pready tied high
//            prdata, pready
//
// Load beats leave busy low. A compute beat raises busy and runs one
// multiply-accumulate per cycle over the matrix column by column; the single
// multiplier and the one read port of each store set that rate. Results leave
// one per column, each for one cycle. Reset is synchronous and sets size_in_use
// to 64; the stores hold no defined value until written.
`include "assert_macros.svh"

module matrix_transpose_vector_multiply_unit #(
    parameter int MAX_N = mtvm_pkg::MAX_N_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                start,
    output logic                                busy,
    input  logic [mtvm_pkg::MODE_W-1:0]         i_mode,
    input  logic [mtvm_pkg::IDX_W-1:0]          i_row,
    input  logic [mtvm_pkg::IDX_W-1:0]          i_col,
    input  logic signed [mtvm_pkg::VAL_W-1:0]   i_value,

    output logic                                o_valid,
    output logic [mtvm_pkg::IDX_W-1:0]          o_column,
    output logic signed [mtvm_pkg::SUM_W-1:0]   o_total,
    output logic                                o_last,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mtvm_pkg::PADDR_W-1:0]        paddr,
    input  logic [mtvm_pkg::PDATA_W-1:0]        pwdata,
    output logic [mtvm_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import mtvm_pkg::*;

    localparam int IW        = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int SIDE      = 1 << IW;
    localparam int MAT_DEPTH = SIDE * SIDE;

    // Configuration
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] w_n;
    logic [SIZE_W-1:0] w_nm1;
    logic [IW-1:0]     w_last_idx;
    logic              w_cfg_wr;

    // Stores
    logic signed [VAL_W-1:0] r_vec_mem [SIDE];
    logic signed [VAL_W-1:0] r_mat_mem [MAT_DEPTH];
    logic signed [VAL_W-1:0] r_vec_rd;
    logic signed [VAL_W-1:0] r_mat_rd;

    // Sequencer
    t_state        r_state;
    t_state        n_state;
    logic [IW-1:0] r_row;
    logic [IW-1:0] r_col;
    logic          w_accept;
    logic          w_go;
    logic          w_row_ok;
    logic          w_col_ok;
    logic          w_row_end;
    logic          w_col_end;

    // Pipeline
    t_tag                    r_s1;
    t_tag                    r_s2;
    logic signed [SUM_W-1:0] r_prod;
    logic signed [SUM_W-1:0] r_acc;
    logic                    r_out_valid;
    logic                    r_out_last;
    logic [IDX_W-1:0]        r_out_col;

    // Active size, clamped to 1..MAX_N
    always_comb begin
        if (r_size == '0) begin
            w_n = SIZE_W'(1);
        end else if (r_size > SIZE_W'(MAX_N)) begin
            w_n = SIZE_W'(MAX_N);
        end else begin
            w_n = r_size;
        end
        w_nm1      = w_n - SIZE_W'(1);
        w_last_idx = w_nm1[IW-1:0];
    end

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[PADDR_W-1:2] == REG_SIZE_IN_USE);
    assign prdata   = (paddr[PADDR_W-1:2] == REG_SIZE_IN_USE)
                      ? PDATA_W'(r_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (w_cfg_wr) begin
            r_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_go     = w_accept && (i_mode == MODE_COMPUTE);
    // A vector load only needs its row in range; col is checked for matrix loads
    assign w_row_ok = ({1'b0, i_row} < (IDX_W+1)'(MAX_N));
    assign w_col_ok = ({1'b0, i_col} < (IDX_W+1)'(MAX_N));

    // One write port for loads and one read port for the compute pass per store
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            case (i_mode)
                MODE_LOAD_VEC: begin
                    if (w_row_ok) begin
                        r_vec_mem[i_row[IW-1:0]] <= i_value;
                    end
                end
                MODE_LOAD_MAT: begin
                    if (w_row_ok && w_col_ok) begin
                        r_mat_mem[{i_row[IW-1:0], i_col[IW-1:0]}] <= i_value;
                    end
                end
                default: ;
            endcase
        end
        r_vec_rd <= r_vec_mem[r_row];
        r_mat_rd <= r_mat_mem[{r_row, r_col}];
    end

    assign w_row_end = (r_row == w_last_idx);
    assign w_col_end = (r_col == w_last_idx);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_go) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (w_row_end && w_col_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_out_valid && r_out_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ISSUE) begin
                if (w_row_end) begin
                    r_row <= '0;
                    r_col <= w_col_end ? '0 : r_col + IW'(1);
                end else begin
                    r_row <= r_row + IW'(1);
                end
            end
        end
    end

    // Tags line up with read data (s1), the product (s2) and the sum (out)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_s1.valid     <= (r_state == ST_ISSUE);
            r_s1.first_row <= (r_row == '0);
            r_s1.last_row  <= w_row_end;
            r_s1.last_col  <= w_col_end;
            r_s1.col       <= IDX_W'(r_col);
            r_s2           <= r_s1;
            r_out_valid    <= r_s2.valid && r_s2.last_row;
            r_out_last     <= r_s2.valid && r_s2.last_row && r_s2.last_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_mat_rd * r_vec_rd;
        if (r_s2.valid) begin
            r_acc <= r_s2.first_row ? r_prod : r_acc + r_prod;
        end
        r_out_col <= r_s2.col;
    end

    assign o_valid  = r_out_valid;
    assign o_column = r_out_col;
    assign o_total  = r_acc;
    assign o_last   = r_out_last;

    `ASSERT_IMPL(a_beat_while_busy, i_clk, i_rst_n, o_valid, busy, "result beat while idle")
    `ASSERT_NEXT(a_last_frees, i_clk, i_rst_n, o_valid && o_last, !busy, "busy after last beat")
    `ASSERT_NEXT(a_compute_starts, i_clk, i_rst_n, w_go, busy, "compute beat did not start")
    `ASSERT_IMPL(a_idle_empty, i_clk, i_rst_n, !busy, !r_s1.valid && !r_s2.valid, "pipe not drained")

endmodule

### dv/matrix_transpose_vector_multiply_unit_test.sv
// Self-checking testbench for matrix_transpose_vector_multiply_unit: loads, computes and
// size register accesses against an in-bench predictor of the column sums.
// Depends on mtvm_pkg and the unit's RTL only.
module matrix_transpose_vector_multiply_unit_test;
    import mtvm_pkg::*;

    localparam logic [MODE_W-1:0]  MODE_UNUSED      = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_SIZE_IN_USE = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED    = 3'd4;
    localparam int FILL_N         = 8;
    localparam int RANDOM_ITEMS   = 110;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 1000000;

    typedef struct {
        logic [IDX_W-1:0]        column;
        logic signed [SUM_W-1:0] total;
        logic                    last;
    } t_col_sum;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [MODE_W-1:0]         i_mode;
    logic [IDX_W-1:0]          i_row;
    logic [IDX_W-1:0]          i_col;
    logic signed [VAL_W-1:0]   i_value;
    logic                      o_valid;
    logic [IDX_W-1:0]          o_column;
    logic signed [SUM_W-1:0]   o_total;
    logic                      o_last;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    // Bench copy of the block state
    logic signed [VAL_W-1:0]   vec_mem [MAX_N_DEF];
    logic signed [VAL_W-1:0]   mat_mem [MAX_N_DEF][MAX_N_DEF];
    logic [SIZE_W-1:0]         size_reg;
    t_col_sum                  pending_sums [$];
    int unsigned               error_count = 0;
    int unsigned               cycle_count = 0;

    matrix_transpose_vector_multiply_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_mode   (i_mode),
        .i_row    (i_row),
        .i_col    (i_col),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .o_column (o_column),
        .o_total  (o_total),
        .o_last   (o_last),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int active_size();
        if (size_reg == 0) return 1;
        if (size_reg > MAX_N_DEF) return MAX_N_DEF;
        return int'(size_reg);
    endfunction

    function automatic void predict_column_sums();
        int                      n;
        logic signed [SUM_W-1:0] acc;
        t_col_sum                beat;
        n = active_size();
        for (int c = 0; c < n; c++) begin
            acc = '0;
            for (int r = 0; r < n; r++)
                acc += mat_mem[r][c] * vec_mem[r];  // 32-bit signed context, wraps
            beat.column = c[IDX_W-1:0];
            beat.total  = acc;
            beat.last   = (c == n - 1);
            pending_sums.push_back(beat);
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic int pick_gap(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // start stays high after a beat; the next negedge either drives a new beat or drops it
    task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] row, col,
                             input logic signed [VAL_W-1:0] value);
        @(negedge i_clk);
        start   <= 1'b1;
        i_mode  <= mode;
        i_row   <= row;
        i_col   <= col;
        i_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        case (mode)
            MODE_LOAD_VEC: vec_mem[row] = value;
            MODE_LOAD_MAT: mat_mem[row][col] = value;
            MODE_COMPUTE:  predict_column_sums();
            default: ;
        endcase
    endtask

    task automatic idle_for(int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_sums.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        start   <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (addr[2] == REG_SIZE_IN_USE)
            size_reg = data[SIZE_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_reg(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        start   <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_size_reg();
        logic [PDATA_W-1:0] got;
        read_reg(ADDR_SIZE_IN_USE, got);
        if (got !== PDATA_W'(size_reg)) begin
            $error("size_in_use: expected %0d, got %0d", size_reg, got);
            error_count++;
        end
    endtask

    task automatic compute();
        send_beat(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
    endtask

    task automatic test_reset_size();
        check_size_reg();
    endtask

    // Fill the corner that every later compute reads, then compute over all of it
    task automatic test_fill_compute();
        for (int r = 0; r < FILL_N; r++) begin
            send_beat(MODE_LOAD_VEC, IDX_W'(r), IDX_W'($urandom), rand_value());
            idle_for(pick_gap(0));
        end
        for (int r = 0; r < FILL_N; r++)
            for (int c = 0; c < FILL_N; c++) begin
                send_beat(MODE_LOAD_MAT, IDX_W'(r), IDX_W'(c), rand_value());
                idle_for(pick_gap(r[0]));
            end
        write_reg(ADDR_SIZE_IN_USE, PDATA_W'(FILL_N));
        compute();
    endtask

    // Column 0 is 3 * 2^30 and overflows into the sign bit
    task automatic test_wrap_extremes();
        wait_idle();
        write_reg(ADDR_SIZE_IN_USE, 32'd3);
        for (int r = 0; r < 3; r++) begin
            send_beat(MODE_LOAD_VEC, IDX_W'(r), 6'd63, 16'sh8000);
            send_beat(MODE_LOAD_MAT, IDX_W'(r), 6'd0, 16'sh8000);
            send_beat(MODE_LOAD_MAT, IDX_W'(r), 6'd1, 16'sh7FFF);
        end
        send_beat(MODE_LOAD_MAT, 6'd0, 6'd2, 16'sh0000);
        send_beat(MODE_LOAD_MAT, 6'd1, 6'd2, -16'sd1);
        send_beat(MODE_LOAD_MAT, 6'd2, 6'd2, 16'sh7FFF);
        compute();
    endtask

    // Unused mode and stores beyond the active size must not touch the sums
    task automatic test_ignored_items();
        wait_idle();
        write_reg(ADDR_SIZE_IN_USE, 32'd2);
        send_beat(MODE_UNUSED, '1, '1, '1);
        send_beat(MODE_UNUSED, '0, '0, '0);
        send_beat(MODE_LOAD_VEC, 6'd63, 6'd0, 16'sh7FFF);
        send_beat(MODE_LOAD_MAT, 6'd63, 6'd63, 16'sh8000);
        send_beat(MODE_LOAD_MAT, 6'd0, 6'd63, -16'sd1);
        send_beat(MODE_LOAD_MAT, 6'd63, 6'd0, 16'sh1234);
        compute();
    endtask

    task automatic test_size_limits();
        wait_idle();
        write_reg(ADDR_SIZE_IN_USE, 32'd0);      // clamps to one
        compute();
        wait_idle();
        write_reg(ADDR_UNMAPPED, 32'd5);         // no such register
        compute();
        wait_idle();
        write_reg(ADDR_SIZE_IN_USE, 32'd1);
        compute();
        wait_idle();
        write_reg(ADDR_SIZE_IN_USE, 32'hFFFF_FFFF);  // stored as 127, read back raw
        check_size_reg();
        write_reg(ADDR_SIZE_IN_USE, 32'd4);
    endtask

    task automatic test_random_traffic();
        int                  n;
        int                  loads;
        int                  done;
        int                  kind;
        int                  sel;
        bit                  burst;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    col;
        logic [PDATA_W-1:0]  data;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 4) == 0);
            if (active_size() > FILL_N || $urandom_range(0, 2) == 0) begin
                wait_idle();
                data = $urandom;
                kind = $urandom_range(0, 19);
                if (kind < 18)
                    data[SIZE_W-1:0] = SIZE_W'($urandom_range(1, FILL_N));
                else if (kind == 18)
                    data[SIZE_W-1:0] = '0;
                write_reg((kind == 19) ? ADDR_UNMAPPED : ADDR_SIZE_IN_USE, data);
            end
            n = active_size();
            loads = $urandom_range(0, (2 * n > 24) ? 24 : 2 * n);
            repeat (loads) begin
                sel = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 85) begin
                    row = IDX_W'($urandom_range(0, n - 1));
                    col = IDX_W'($urandom_range(0, n - 1));
                end else begin
                    row = IDX_W'($urandom);
                    col = IDX_W'($urandom);
                end
                if (sel < 5) begin
                    send_beat(MODE_UNUSED, row, col, VAL_W'($urandom));
                end else begin
                    send_beat((sel < 40) ? MODE_LOAD_VEC : MODE_LOAD_MAT, row, col, rand_value());
                    done++;
                end
                idle_for(pick_gap(burst));
            end
            compute();
            done++;
            if ($urandom_range(0, 4) == 0) begin
                idle_for(pick_gap(burst));
                compute();
                done++;
            end
            idle_for(pick_gap(burst));
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_col_sum want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_sums.size() == 0) begin
                $error("unexpected result beat: column %0d total %0d last %0b",
                       o_column, o_total, o_last);
                error_count++;
            end else begin
                want = pending_sums.pop_front();
                if (o_column !== want.column) begin
                    $error("column: expected %0d, got %0d", want.column, o_column);
                    error_count++;
                end
                if (o_total !== want.total) begin
                    $error("total: expected %0d, got %0d", want.total, o_total);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_mode   = MODE_LOAD_VEC;
        i_row    = '0;
        i_col    = '0;
        i_value  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        size_reg = SIZE_RESET;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_size();
        test_fill_compute();
        test_wrap_extremes();
        test_ignored_items();
        test_size_limits();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_sums.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_sums.size());
            error_count++;
        end
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/mtvm_pkg.sv
src/matrix_transpose_vector_multiply_unit.sv
dv/matrix_transpose_vector_multiply_unit_test.sv
